FILE: sv/matrix3_determinant_inverse_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Included by the top level; no other dependencies.
`ifndef MATRIX3_DETERMINANT_INVERSE_ASSERT_SVH
`define MATRIX3_DETERMINANT_INVERSE_ASSERT_SVH
`ifndef SYNTHESIS
`define MDI_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mdi assertion failed");
`define MDI_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mdi assertion failed");
`else
`define MDI_ASSERT_IMP(label, clk, rst, a, b)
`define MDI_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

FILE: sv/mdi_pkg.sv
// Package for the 3x3 matrix inverse block: widths, defaults, cofactor
// product index tables. No dependencies.
package mdi_pkg;
  localparam int IN_FRAC_BITS_DEF  = 8;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ADJ_W    = 33;
  localparam int DET_W    = 49;
  localparam int DMAG_W   = 48;
  localparam int NMAG_W   = 32;
  localparam int OUT_W    = 32;
  localparam int QUO_BITS = 32;
  localparam int NUM_ELEM = 9;
  localparam int NUM_PROD = 18;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic [3:0] idx_t;
  typedef idx_t prod_tab_t [NUM_PROD];

  // adjugate entry k = prod[2k] - prod[2k+1]; elements indexed row*3+col
  localparam prod_tab_t PROD_A = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2,
                                   4'd5, 4'd3, 4'd0, 4'd2, 4'd2, 4'd0,
                                   4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam prod_tab_t PROD_B = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4,
                                   4'd6, 4'd8, 4'd8, 4'd6, 4'd3, 4'd5,
                                   4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};
endpackage

FILE: sv/matrix3_determinant_inverse.sv
// 3x3 matrix inverse via adjugate / determinant, Q8.8 in, Q16.16 out.
// Depends on mdi_pkg and matrix3_determinant_inverse_assert.svh.
//
// Usage:
//   Slave stream carries one matrix per beat, nine signed elements in tdata,
//   row-major, element r0c0 in the lowest 16 bits. Master stream returns one
//   beat per matrix: nine signed inverse elements in tdata (r0c0 lowest) and
//   the invertible flag in tuser. A singular matrix returns zeros, flag low.
//   The result beat passes through 40 register stages: input, products,
//   cofactors, determinant terms, determinant, magnitudes, divider setup,
//   one restoring-division step per stage for 32 quotient bits, then a
//   rounding/saturation output stage. Each stage holds one beat.
//   Throughput is one matrix per cycle when the receiver does not stall.
//   When the receiver stalls, the output beat holds and bubbles inside the
//   pipeline collapse; s_axis_tready drops only once every stage is full.
//   Reset (rst, synchronous) clears all valid bits; no data is flushed
//   beyond that.
`include "matrix3_determinant_inverse_assert.svh"

module matrix3_determinant_inverse #(
  parameter int IN_FRAC_BITS  = mdi_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = mdi_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // elem_r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2, r2_c0, r2_c1, r2_c2
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // inv_r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2, r2_c0, r2_c1, r2_c2
  output logic [287:0] m_axis_tdata,
  // invertible
  output logic [0:0]   m_axis_tuser
);
  localparam int SH    = IN_FRAC_BITS + OUT_FRAC_BITS + 1;
  localparam int DVW   = mdi_pkg::NMAG_W + SH;
  localparam int TW    = DVW - mdi_pkg::QUO_BITS;
  localparam int CW    = (TW > mdi_pkg::DMAG_W) ? TW : mdi_pkg::DMAG_W;
  localparam int NDIV  = mdi_pkg::QUO_BITS;
  localparam int ST_DIV0 = 6;
  localparam int NST   = ST_DIV0 + NDIV + 2;
  localparam int NE    = mdi_pkg::NUM_ELEM;

  logic [NST-1:0] v, en;

  assign en[NST-1] = !v[NST-1] || m_axis_tready;
  for (genvar k = 0; k < NST-1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: input
  logic signed [mdi_pkg::ELEM_W-1:0] e0 [NE];
  // stage 1: products
  logic signed [mdi_pkg::PROD_W-1:0] p1 [mdi_pkg::NUM_PROD];
  logic signed [mdi_pkg::ELEM_W-1:0] m1 [3];
  // stage 2: adjugate
  logic signed [mdi_pkg::ADJ_W-1:0]  a2 [NE];
  logic signed [mdi_pkg::ELEM_W-1:0] m2 [3];
  // stage 3: determinant terms
  logic signed [mdi_pkg::ADJ_W-1:0]  a3 [NE];
  logic signed [mdi_pkg::DET_W-1:0]  t3 [3];
  // stage 4: determinant
  logic signed [mdi_pkg::ADJ_W-1:0]  a4 [NE];
  logic signed [mdi_pkg::DET_W-1:0]  det4;
  // stage 5: magnitudes
  logic [mdi_pkg::NMAG_W-1:0] n5 [NE];
  logic [NE-1:0]              neg5;
  logic [mdi_pkg::DMAG_W-1:0] d5;
  logic                       inv5;
  // division stages: index 0 is the setup stage
  logic [mdi_pkg::DMAG_W-1:0]   rem [NDIV+1][NE];
  logic [mdi_pkg::QUO_BITS-1:0] lq  [NDIV+1][NE];
  logic [NE-1:0]                neg [NDIV+1];
  logic [NE-1:0]                ovf [NDIV+1];
  logic [mdi_pkg::DMAG_W-1:0]   dm  [NDIV+1];
  logic                         inv [NDIV+1];
  // output
  logic [mdi_pkg::OUT_W-1:0] res [NE];
  logic                      inv_o;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < NE; j++) begin
        e0[j] <= s_axis_tdata[mdi_pkg::ELEM_W*j +: mdi_pkg::ELEM_W];
      end
    end
    if (en[1]) begin
      for (int j = 0; j < mdi_pkg::NUM_PROD; j++) begin
        p1[j] <= e0[mdi_pkg::PROD_A[j]] * e0[mdi_pkg::PROD_B[j]];
      end
      for (int j = 0; j < 3; j++) begin
        m1[j] <= e0[j];
      end
    end
    if (en[2]) begin
      for (int j = 0; j < NE; j++) begin
        a2[j] <= mdi_pkg::ADJ_W'(p1[2*j]) - mdi_pkg::ADJ_W'(p1[2*j+1]);
      end
      m2 <= m1;
    end
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        t3[j] <= m2[j] * a2[3*j];
      end
      a3 <= a2;
    end
    if (en[4]) begin
      det4 <= t3[0] + t3[1] + t3[2];
      a4   <= a3;
    end
    if (en[5]) begin
      for (int j = 0; j < NE; j++) begin
        n5[j]   <= a4[j][mdi_pkg::ADJ_W-1] ? mdi_pkg::NMAG_W'(-a4[j])
                                           : mdi_pkg::NMAG_W'(a4[j]);
        neg5[j] <= a4[j][mdi_pkg::ADJ_W-1] ^ det4[mdi_pkg::DET_W-1];
      end
      d5   <= det4[mdi_pkg::DET_W-1] ? mdi_pkg::DMAG_W'(-det4)
                                     : mdi_pkg::DMAG_W'(det4);
      inv5 <= (det4 != '0);
    end
  end

  // setup: split the scaled dividend, detect quotient overflow
  logic [DVW-1:0] dv [NE];
  logic [CW-1:0]  tc [NE];
  always_comb begin
    for (int j = 0; j < NE; j++) begin
      dv[j] = DVW'(n5[j]) << SH;
      tc[j] = CW'(dv[j][DVW-1:mdi_pkg::QUO_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) begin
      for (int j = 0; j < NE; j++) begin
        rem[0][j] <= tc[j][mdi_pkg::DMAG_W-1:0];
        lq[0][j]  <= dv[j][mdi_pkg::QUO_BITS-1:0];
        ovf[0][j] <= (tc[j] >= CW'(d5));
      end
      neg[0] <= neg5;
      dm[0]  <= d5;
      inv[0] <= inv5;
    end
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [mdi_pkg::DMAG_W:0] r2 [NE];
    logic [mdi_pkg::DMAG_W:0] df [NE];
    logic [NE-1:0]            ge;
    always_comb begin
      for (int j = 0; j < NE; j++) begin
        r2[j] = {rem[k-1][j], lq[k-1][j][mdi_pkg::QUO_BITS-1]};
        df[j] = r2[j] - {1'b0, dm[k-1]};
        ge[j] = (r2[j] >= {1'b0, dm[k-1]});
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_DIV0+k]) begin
        for (int j = 0; j < NE; j++) begin
          rem[k][j] <= ge[j] ? df[j][mdi_pkg::DMAG_W-1:0]
                             : r2[j][mdi_pkg::DMAG_W-1:0];
          lq[k][j]  <= {lq[k-1][j][mdi_pkg::QUO_BITS-2:0], ge[j]};
        end
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
        dm[k]  <= dm[k-1];
        inv[k] <= inv[k-1];
      end
    end
  end

  // round half away from zero, saturate, apply sign
  logic [mdi_pkg::QUO_BITS:0]   rnd [NE];
  logic [mdi_pkg::OUT_W-1:0]    mg  [NE];
  logic [NE-1:0]                sat;
  always_comb begin
    for (int j = 0; j < NE; j++) begin
      rnd[j] = {1'b0, lq[NDIV][j]} + 1'b1;
      mg[j]  = rnd[j][mdi_pkg::QUO_BITS:1];
      sat[j] = ovf[NDIV][j] || mg[j][mdi_pkg::OUT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int j = 0; j < NE; j++) begin
        if (!inv[NDIV]) begin
          res[j] <= '0;
        end else if (neg[NDIV][j]) begin
          res[j] <= sat[j] ? mdi_pkg::OUT_MIN : (~mg[j] + 1'b1);
        end else begin
          res[j] <= sat[j] ? mdi_pkg::OUT_MAX : mg[j];
        end
      end
      inv_o <= inv[NDIV];
    end
  end

  for (genvar j = 0; j < NE; j++) begin : g_out
    assign m_axis_tdata[mdi_pkg::OUT_W*j +: mdi_pkg::OUT_W] = res[j];
  end
  assign m_axis_tuser = inv_o;

  `MDI_ASSERT_IMP(a_full_when_blocked, clk, rst, !s_axis_tready, &v)
  `MDI_ASSERT_IMP(a_singular_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
                  m_axis_tdata == '0)
  `MDI_ASSERT_IMP(a_rem_bound, clk, rst, v[NST-2] && inv[NDIV] && !ovf[NDIV][0],
                  rem[NDIV][0] < dm[NDIV])
  `MDI_ASSERT_NXT(a_drain, clk, rst, m_axis_tvalid && m_axis_tready && !v[NST-2],
                  !m_axis_tvalid)
endmodule
